/* rtl/double_ended_queue_unit_assert.svh */
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int FILL_W        = 7;

    localparam logic signed [WORD_W-1:0] POP_EMPTY_WORD = '1;
    localparam logic signed [WORD_W-1:0] PUSH_WORD      = '0;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic en;
        t_op  op;
    } t_cell_cmd;

endpackage

/* rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue: a chain of cells, count, sequencer and output register.
//
//   channel | valid      | ready       | payload
//   request | i_in_valid | o_in_ready  | i_opcode, i_push_value
//   result  | o_out_valid| i_out_ready | o_popped_value, o_status, o_fill_count, o_is_empty
//
// Push back, push front, pop front and any refused or empty operation write the output register on acceptance.
// Pop back first walks the back word down the return path to the head, one cell per cycle.
// Reset (synchronous, active low) clears the cell valid bits, the count, the sequencer and the output valid bit.
// The output register holds a word until taken; a new word is accepted in the cycle it is.
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_push_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [deq_pkg::WORD_W-1:0]  o_popped_value,
    output logic [1:0]                         o_status,
    output logic [deq_pkg::FILL_W-1:0]         o_fill_count,
    output logic                               o_is_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_state    r_state;
    deq_pkg::t_state    n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_wait;
    logic [CW-1:0]      n_wait;

    logic                              r_out_valid;
    logic                              n_out_valid;
    logic signed [deq_pkg::WORD_W-1:0] r_out_value;
    logic signed [deq_pkg::WORD_W-1:0] n_out_value;
    deq_pkg::t_status                  r_out_status;
    deq_pkg::t_status                  n_out_status;
    logic [CW-1:0]                     r_out_count;
    logic [CW-1:0]                     n_out_count;

    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_is_push;
    logic                              w_ok_push;
    logic                              w_ok_pop;
    deq_pkg::t_op                      w_op;
    deq_pkg::t_cell_cmd                w_cmd;
    logic [CW+deq_pkg::FILL_W-1:0]     w_fill_wide;

    logic                              w_valid [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] w_data  [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] w_ret   [DEPTH];

    assign w_op       = deq_pkg::t_op'(i_opcode);
    assign o_in_ready = (r_state == deq_pkg::S_IDLE) & (~r_out_valid | i_out_ready);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_is_push  = (w_op == deq_pkg::OP_PUSH_BACK) || (w_op == deq_pkg::OP_PUSH_FRONT);
    assign w_ok_push  = w_is_push & ~w_full;
    assign w_ok_pop   = ~w_is_push & ~w_empty;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                              w_pv;
        logic signed [deq_pkg::WORD_W-1:0] w_pd;
        logic                              w_nv;
        logic signed [deq_pkg::WORD_W-1:0] w_nd;
        logic signed [deq_pkg::WORD_W-1:0] w_nr;

        if (g == 0) begin : g_head
            assign w_pv = 1'b1;
            assign w_pd = i_push_value;
        end else begin : g_mid
            assign w_pv = w_valid[g-1];
            assign w_pd = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_nv = 1'b0;
            assign w_nd = '0;
            assign w_nr = '0;
        end else begin : g_body
            assign w_nv = w_valid[g+1];
            assign w_nd = w_data[g+1];
            assign w_nr = w_ret[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_push_value (i_push_value),
            .i_prev_valid (w_pv),
            .i_prev_data  (w_pd),
            .i_next_valid (w_nv),
            .i_next_data  (w_nd),
            .i_next_ret   (w_nr),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_ret        (w_ret[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (w_accept && w_op == deq_pkg::OP_POP_BACK && !w_empty) begin
                    n_state = deq_pkg::S_DRAIN;
                end
            end
            deq_pkg::S_DRAIN: begin
                if (r_wait == '0) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        w_cmd.en     = 1'b0;
        w_cmd.op     = w_op;
        n_count      = r_count;
        n_wait       = r_wait;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_cmd.en = w_ok_push | w_ok_pop;
                    priority if (w_ok_push) begin
                        n_count = r_count + CW'(1);
                    end else if (w_ok_pop) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_count = r_count;
                    end
                    if (w_op == deq_pkg::OP_POP_BACK && !w_empty) begin
                        n_wait = r_count - CW'(1);
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_count = n_count;
                        priority if (w_is_push) begin
                            n_out_value  = deq_pkg::PUSH_WORD;
                            n_out_status = w_full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
                        end else if (w_empty) begin
                            n_out_value  = deq_pkg::POP_EMPTY_WORD;
                            n_out_status = deq_pkg::ST_EMPTY;
                        end else begin
                            n_out_value  = w_data[0];
                            n_out_status = deq_pkg::ST_OK;
                        end
                    end
                end
            end
            deq_pkg::S_DRAIN: begin
                if (r_wait == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_ret[0];
                    n_out_status = deq_pkg::ST_OK;
                    n_out_count  = r_count;
                end else begin
                    n_wait = r_wait - CW'(1);
                end
            end
            default: begin
                n_wait = r_wait;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_wait       <= n_wait;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign w_fill_wide    = {{deq_pkg::FILL_W{1'b0}}, r_out_count};
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_fill_count   = w_fill_wide[deq_pkg::FILL_W-1:0];
    assign o_is_empty     = (r_out_count == '0);

    `DEQ_ASSERT_NOW(a_head_matches_count, 1'b1, w_valid[0] == (r_count != '0), "head valid bit disagrees with count")
    `DEQ_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `DEQ_ASSERT_NEXT(a_push_front_head, w_accept && w_op == deq_pkg::OP_PUSH_FRONT && !w_full, w_data[0] == $past(i_push_value), "pushed front word not at head")
    `DEQ_ASSERT_NEXT(a_pop_back_drains, w_accept && w_op == deq_pkg::OP_POP_BACK && !w_empty, r_state == deq_pkg::S_DRAIN && !o_in_ready, "pop back did not start return walk")

endmodule

/* rtl/deq_cell.sv */
// One storage cell of the queue chain: a word, its valid bit and a return-path stage.
module deq_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  deq_pkg::t_cell_cmd               i_cmd,
    input  logic signed [deq_pkg::WORD_W-1:0] i_push_value,
    input  logic                             i_prev_valid,
    input  logic signed [deq_pkg::WORD_W-1:0] i_prev_data,
    input  logic                             i_next_valid,
    input  logic signed [deq_pkg::WORD_W-1:0] i_next_data,
    input  logic signed [deq_pkg::WORD_W-1:0] i_next_ret,
    output logic                             o_valid,
    output logic signed [deq_pkg::WORD_W-1:0] o_data,
    output logic signed [deq_pkg::WORD_W-1:0] o_ret
);

    logic                              r_valid;
    logic                              n_valid;
    logic signed [deq_pkg::WORD_W-1:0] r_data;
    logic signed [deq_pkg::WORD_W-1:0] n_data;
    logic signed [deq_pkg::WORD_W-1:0] r_ret;
    logic signed [deq_pkg::WORD_W-1:0] n_ret;
    logic                              w_tail;
    logic                              w_first_free;

    assign w_tail       = r_valid & ~i_next_valid;
    assign w_first_free = i_prev_valid & ~r_valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_ret   = i_next_ret;
        if (i_cmd.en) begin
            unique case (i_cmd.op)
                deq_pkg::OP_PUSH_BACK: begin
                    if (w_first_free) begin
                        n_valid = 1'b1;
                        n_data  = i_push_value;
                    end
                end
                deq_pkg::OP_PUSH_FRONT: begin
                    n_valid = i_prev_valid;
                    n_data  = i_prev_data;
                end
                deq_pkg::OP_POP_FRONT: begin
                    n_valid = i_next_valid;
                    n_data  = i_next_data;
                end
                deq_pkg::OP_POP_BACK: begin
                    if (w_tail) begin
                        n_valid = 1'b0;
                        n_ret   = r_data;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
        r_ret  <= n_ret;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_ret   = r_ret;

endmodule
